// File: sv/ttanf_pkg.sv
// ----------------------------------------------------------------------------
// ttanf_pkg: shared types and functions for the truth table to ANF block
// Holds the channel payloads, the queue command, the sequencer states and
// the in-word transform helpers.
// ----------------------------------------------------------------------------
package ttanf_pkg;

    localparam int WORD_BITS  = 64;
    localparam int WNUM_W     = 4;
    localparam int VAR_W      = 4;
    // Wide enough for a fill count of the largest store (MAX_VARS of 16).
    localparam int CMD_CNT_W  = 11;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int IN_WORD_VARS = 6;

    // Register index taken from the word address.
    localparam logic REG_VAR_COUNT = 1'b0;

    localparam logic [IN_WORD_VARS-1:0][WORD_BITS-1:0] HALF_MASK = {
        64'h0000_0000_FFFF_FFFF,
        64'h0000_FFFF_0000_FFFF,
        64'h00FF_00FF_00FF_00FF,
        64'h0F0F_0F0F_0F0F_0F0F,
        64'h3333_3333_3333_3333,
        64'h5555_5555_5555_5555
    };

    typedef struct packed {
        logic [WORD_BITS-1:0] table_word;
        logic                 final_word;
    } t_in;

    typedef struct packed {
        logic [WORD_BITS-1:0] anf_word;
        logic [WNUM_W-1:0]    word_number;
        logic                 end_of_form;
    } t_out;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
        logic                 store;
        logic [CMD_CNT_W-1:0] count;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WORD_RD,
        ST_WORD_WR,
        ST_CROSS_RD,
        ST_CROSS_WR,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    // Moebius transform over the variables that live inside one word.
    function automatic logic [WORD_BITS-1:0] moebius_word(
        input logic [WORD_BITS-1:0] x,
        input logic [VAR_W-1:0]     n
    );
        logic [WORD_BITS-1:0] y;
        y = x;
        for (int v = 0; v < IN_WORD_VARS; v++) begin
            if (VAR_W'(v) < n) begin
                y = y ^ ((y & HALF_MASK[v]) << (1 << v));
            end
        end
        return y;
    endfunction

    // Keep only the 2^n coefficients that exist for a small function.
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [VAR_W-1:0] n);
        logic [6:0] sh;
        sh = 7'd0;
        if (n >= VAR_W'(IN_WORD_VARS)) begin
            return {WORD_BITS{1'b1}};
        end
        sh = 7'd1 << n[2:0];
        return ~({WORD_BITS{1'b1}} << sh);
    endfunction

endpackage

// File: sv/ttanf_ram.sv
// ----------------------------------------------------------------------------
// ttanf_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ttanf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                         o_rdata_a,
    output logic [WIDTH-1:0]                         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: sv/ttanf_front.sv
// ----------------------------------------------------------------------------
// ttanf_front: input classifier
// Counts loaded words, decides whether each word is stored and where, and
// hands it to the command queue together with its end-of-table flag.
// ----------------------------------------------------------------------------
module ttanf_front #(
    parameter int MAX_VARS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ttanf_pkg::t_in  i_in_data,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output ttanf_pkg::t_cmd o_cmd
);
    import ttanf_pkg::*;

    localparam int STORE_WORDS = 2 ** (MAX_VARS - IN_WORD_VARS);
    localparam int ADDR_W      = (MAX_VARS > IN_WORD_VARS) ? MAX_VARS - IN_WORD_VARS : 1;
    localparam int CNT_W       = ADDR_W + 1;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             store;
    logic             accept;

    assign store       = r_count < CNT_W'(STORE_WORDS);
    assign accept      = i_in_valid && i_cmd_ready;
    assign o_in_ready  = i_cmd_ready;
    assign o_cmd_valid = i_in_valid;

    always_comb begin
        o_cmd.word  = i_in_data.table_word;
        o_cmd.last  = i_in_data.final_word;
        o_cmd.store = store;
        o_cmd.count = CMD_CNT_W'(r_count);
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_in_data.final_word) begin
                n_count = '0;
            end else if (store) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// File: sv/ttanf_queue.sv
// ----------------------------------------------------------------------------
// ttanf_queue: two-entry command queue
// Decouples the classifier from the transform sequencer.
// ----------------------------------------------------------------------------
module ttanf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  ttanf_pkg::t_cmd i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output ttanf_pkg::t_cmd o_pop_data
);
    import ttanf_pkg::*;

    localparam int DEPTH = 2;

    t_cmd       r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic       push;
    logic       pop;

    assign o_push_ready = r_level != 2'(DEPTH);
    assign o_pop_valid  = r_level != 2'd0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_level <= r_level + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: sv/ttanf_back.sv
// ----------------------------------------------------------------------------
// ttanf_back: transform sequencer
// Stores words, runs the in-word and cross-word Moebius passes over the
// table RAM, and emits the coefficient words through an output register.
// ----------------------------------------------------------------------------
module ttanf_back #(
    parameter int MAX_VARS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ttanf_pkg::VAR_W-1:0] i_var_count,
    input  logic                     i_cmd_valid,
    output logic                     o_cmd_ready,
    input  ttanf_pkg::t_cmd          i_cmd,
    output logic                     o_we,
    output logic [((MAX_VARS > 6) ? MAX_VARS - 6 : 1)-1:0] o_waddr,
    output logic [ttanf_pkg::WORD_BITS-1:0] o_wdata,
    output logic [((MAX_VARS > 6) ? MAX_VARS - 6 : 1)-1:0] o_raddr_a,
    output logic [((MAX_VARS > 6) ? MAX_VARS - 6 : 1)-1:0] o_raddr_b,
    input  logic [ttanf_pkg::WORD_BITS-1:0] i_rdata_a,
    input  logic [ttanf_pkg::WORD_BITS-1:0] i_rdata_b,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output ttanf_pkg::t_out          o_out_data
);
    import ttanf_pkg::*;

    localparam int ADDR_W = (MAX_VARS > IN_WORD_VARS) ? MAX_VARS - IN_WORD_VARS : 1;
    localparam int CNT_W  = ADDR_W + 1;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_w, n_w;
    logic [VAR_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic [VAR_W-1:0]  n_var;
    logic [VAR_W-1:0]  cross_cnt;
    logic [CNT_W-1:0]  words;
    logic [ADDR_W-1:0] last_w;
    logic              w_last;
    logic [ADDR_W-1:0] d_mask;
    logic              skip;
    logic              in_range;
    t_state            adv_state;
    logic [ADDR_W-1:0] adv_w;
    logic [VAR_W-1:0]  adv_k;

    // Clamp the variable count and derive the table geometry.
    assign n_var     = (int'(i_var_count) > MAX_VARS) ? VAR_W'(MAX_VARS) : i_var_count;
    assign cross_cnt = (n_var > VAR_W'(IN_WORD_VARS)) ? n_var - VAR_W'(IN_WORD_VARS) : '0;
    assign words     = (n_var > VAR_W'(IN_WORD_VARS)) ? (CNT_W'(1) << cross_cnt) : CNT_W'(1);
    assign last_w    = ADDR_W'(words - CNT_W'(1));
    assign w_last    = r_w == last_w;
    assign d_mask    = ADDR_W'(1) << r_k;
    assign skip      = (r_w & d_mask) != '0;
    assign in_range  = {1'b0, r_w} < r_fill;

    assign o_raddr_a   = r_w;
    assign o_raddr_b   = r_w | d_mask;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Step to the next pair of a cross-word pass, or the next pass.
    always_comb begin
        adv_state = ST_CROSS_RD;
        adv_w     = r_w + ADDR_W'(1);
        adv_k     = r_k;
        if (w_last) begin
            adv_w = '0;
            if (r_k == cross_cnt - VAR_W'(1)) begin
                adv_state = ST_EMIT_RD;
            end else begin
                adv_k = r_k + VAR_W'(1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_k         = r_k;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_cmd_ready = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_w;
        o_wdata     = i_rdata_a;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_we    = i_cmd.store;
                    o_waddr = ADDR_W'(i_cmd.count);
                    o_wdata = i_cmd.word;
                    if (i_cmd.last) begin
                        n_fill  = CNT_W'(i_cmd.count) + CNT_W'(i_cmd.store);
                        n_w     = '0;
                        n_state = ST_WORD_RD;
                    end
                end
            end
            ST_WORD_RD: begin
                n_state = ST_WORD_WR;
            end
            ST_WORD_WR: begin
                // Words past the loaded count read as zero.
                o_we    = 1'b1;
                o_wdata = moebius_word(in_range ? i_rdata_a : '0, n_var);
                if (w_last) begin
                    n_w     = '0;
                    n_k     = '0;
                    n_state = (cross_cnt != '0) ? ST_CROSS_RD : ST_EMIT_RD;
                end else begin
                    n_w     = r_w + ADDR_W'(1);
                    n_state = ST_WORD_RD;
                end
            end
            ST_CROSS_RD: begin
                if (skip) begin
                    n_state = adv_state;
                    n_w     = adv_w;
                    n_k     = adv_k;
                end else begin
                    n_state = ST_CROSS_WR;
                end
            end
            ST_CROSS_WR: begin
                o_we    = 1'b1;
                o_waddr = r_w | d_mask;
                o_wdata = i_rdata_a ^ i_rdata_b;
                n_state = adv_state;
                n_w     = adv_w;
                n_k     = adv_k;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.anf_word    = i_rdata_a & low_mask(n_var);
                    n_out.word_number = WNUM_W'(r_w);
                    n_out.end_of_form = w_last;
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_w     = r_w + ADDR_W'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_k    <= n_k;
        r_fill <= n_fill;
        r_out  <= n_out;
    end

endmodule

// File: sv/truth_table_to_anf_mobius.sv
// ----------------------------------------------------------------------------
// truth_table_to_anf_mobius: truth table to algebraic normal form
// Loads a Boolean truth table word by word and emits its ANF coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Write var_count (number of variables n) over the APB port at address 0
//   while the block is idle. Send truth-table words on the input channel,
//   lowest minterm first; flag the last one with final_word. Each word is one
//   transaction. Words past the store size are dropped; missing words read
//   as zero.
//   After the final word the block emits W = 2^(n-6) coefficient words (one
//   for n <= 6) on the output channel, word_number counting up from zero and
//   end_of_form set on the last one.
// Flow:
//   Words stream in at one per cycle while the command queue has room. After
//   the final word the sequencer runs the in-word pass (a read and a write per
//   word), one cross-word pass per variable above six (a read and a write per
//   pair) and then the emit. The table RAM has two read ports and one write
//   port. A two-entry queue takes up to two words of the next table.
// Reset and stalls:
//   Reset clears var_count, the word count, the queue and the output valid. A
//   stalled receiver holds the output register and pauses the emit; the
//   queue then fills and the input deasserts ready.
// ----------------------------------------------------------------------------
module truth_table_to_anf_mobius #(
    parameter int MAX_VARS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ttanf_pkg::PADDR_W-1:0] paddr,
    input  logic [ttanf_pkg::PDATA_W-1:0] pwdata,
    output logic [ttanf_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ttanf_pkg::t_in               i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ttanf_pkg::t_out              o_out_data
);
    import ttanf_pkg::*;

    localparam int ADDR_W    = (MAX_VARS > IN_WORD_VARS) ? MAX_VARS - IN_WORD_VARS : 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    logic [VAR_W-1:0]     r_var_count;
    logic                 cfg_write;
    logic                 cmd_valid_f;
    logic                 cmd_ready_f;
    t_cmd                 cmd_f;
    logic                 cmd_valid_b;
    logic                 cmd_ready_b;
    t_cmd                 cmd_b;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr_a;
    logic [ADDR_W-1:0]    ram_raddr_b;
    logic [WORD_BITS-1:0] ram_rdata_a;
    logic [WORD_BITS-1:0] ram_rdata_b;

    // Configuration: one register, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_VAR_COUNT);
    assign prdata    = (paddr[2] == REG_VAR_COUNT) ? PDATA_W'(r_var_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_count <= '0;
        end else if (cfg_write) begin
            r_var_count <= pwdata[VAR_W-1:0];
        end
    end

    // Classify incoming words and assign store slots.
    ttanf_front #(
        .MAX_VARS (MAX_VARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid_f),
        .i_cmd_ready (cmd_ready_f),
        .o_cmd       (cmd_f)
    );

    // Buffer commands so the input keeps moving while the transform runs.
    ttanf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (cmd_valid_f),
        .o_push_ready (cmd_ready_f),
        .i_push_data  (cmd_f),
        .o_pop_valid  (cmd_valid_b),
        .i_pop_ready  (cmd_ready_b),
        .o_pop_data   (cmd_b)
    );

    // Store, transform and emit.
    ttanf_back #(
        .MAX_VARS (MAX_VARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_var_count (r_var_count),
        .i_cmd_valid (cmd_valid_b),
        .o_cmd_ready (cmd_ready_b),
        .i_cmd       (cmd_b),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr_a   (ram_raddr_a),
        .o_raddr_b   (ram_raddr_b),
        .i_rdata_a   (ram_rdata_a),
        .i_rdata_b   (ram_rdata_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Table store.
    ttanf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_table_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

endmodule

// File: sv/ttanf_checker.sv
// ----------------------------------------------------------------------------
// ttanf_checker: port-level checks
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
module ttanf_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input ttanf_pkg::t_out o_out_data
);
    import ttanf_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // Advance the word number by one between back-to-back results of a run.
    a_word_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.end_of_form |=>
            !o_out_valid ||
            o_out_data.word_number == $past(o_out_data.word_number) + WNUM_W'(1))
        else $error("coefficient word number skipped");

    // Drop valid after the last word of a run.
    a_end_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.end_of_form |=> !o_out_valid)
        else $error("result follows end of form without a new table");

endmodule

bind truth_table_to_anf_mobius ttanf_checker u_ttanf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
